### rtl/vng_pkg.sv
`timescale 1ns / 1ps
package vng_pkg;

   // item kinds
   localparam logic [1:0] KIND_POSITION = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_QUERY    = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   // corner / component select
   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;

   // last step of each sequenced phase
   localparam logic [4:0] CROSS_LAST = 5'd6;
   localparam logic [4:0] SQ_LAST    = 5'd3;
   localparam logic [4:0] SQRT_LAST  = 5'd31;
   localparam logic [4:0] DIV_LAST   = 5'd16;

   // normalization window: largest magnitude in [2^30, 2^31)
   localparam int NORM_HI_BIT = 31;
   localparam int NORM_LO_BIT = 30;

   localparam logic [63:0]       SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
   localparam logic signed [15:0] UNIT_MAX     = 16'sd32767;

   typedef enum logic [4:0] {
      S_IDLE,
      S_T_RA,
      S_T_RB,
      S_T_RC,
      S_T_CAPC,
      S_T_EDGE,
      S_T_CROSS,
      S_T_ACC_RD,
      S_T_ACC_WR,
      S_Q_RD,
      S_Q_MAG,
      S_Q_NORM,
      S_Q_SQ,
      S_Q_SQRT,
      S_Q_DIV_INIT,
      S_Q_DIV,
      S_Q_DIV_STORE,
      S_Q_OUT,
      S_Q_DEGEN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_POS_WRITE,
      OP_RD_A,
      OP_RD_B,
      OP_RD_C,
      OP_CAP_C,
      OP_EDGE,
      OP_CROSS,
      OP_ACC_RD,
      OP_ACC_WR,
      OP_Q_RD,
      OP_MAG,
      OP_NORM,
      OP_SQUARE,
      OP_SQRT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_OUT_LOAD,
      OP_OUT_DEGEN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] step;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic vi_ok;
      logic tri_ok;
      logic acc_zero;
      logic norm_done;
   } status_type;

endpackage

### rtl/vng_dpath.sv
`timescale 1ns / 1ps
module vng_dpath #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_WIDTH  = 24,
   parameter int ACCUM_WIDTH  = 56
) (
   input  logic                clock,
   input  logic [9:0]          req_vertex_index,
   input  logic signed [23:0]  req_pos_x,
   input  logic signed [23:0]  req_pos_y,
   input  logic signed [23:0]  req_pos_z,
   input  logic [9:0]          req_corner_a,
   input  logic [9:0]          req_corner_b,
   input  logic [9:0]          req_corner_c,
   input  vng_pkg::cmd_type    cmd,
   output vng_pkg::status_type status,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z,
   output logic                rsp_degenerate
);
   import vng_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int AW     = ACCUM_WIDTH;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int IDX_W  = (ADDR_W > 10) ? ADDR_W : 10;
   localparam int EW     = CW + 1;
   localparam int MW     = (EW > 32) ? EW : 32;
   localparam int PW     = 2 * MW;
   localparam int DW     = 2 * EW + 1;
   localparam int SW     = ((AW > DW) ? AW : DW) + 1;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [9:0] idx);
      logic [IDX_W-1:0] w;
      w = IDX_W'(idx);
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic in_range(input logic [9:0] idx);
      return 32'(idx) < 32'(MAX_VERTICES);
   endfunction

   function automatic logic signed [CW-1:0] coord(input logic [3*CW-1:0] p,
                                                   input logic [1:0] k);
      logic signed [CW-1:0] c;
      unique case (k)
         SEL_A:   c = p[3*CW-1:2*CW];
         SEL_B:   c = p[2*CW-1:CW];
         default: c = p[CW-1:0];
      endcase
      return c;
   endfunction

   function automatic logic [AW-1:0] mag_of(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] n;
      n = -v;
      return v[AW-1] ? n : v;
   endfunction

   // saturating accumulate into the signed accumulator range
   function automatic logic [AW-1:0] sat_acc(input logic signed [AW-1:0] a,
                                             input logic signed [DW-1:0] d);
      logic signed [SW-1:0] s;
      logic [AW-1:0]        r;
      s = SW'(a) + SW'(d);
      if ((&s[SW-1:AW-1]) || !(|s[SW-1:AW-1])) begin
         r = s[AW-1:0];
      end else if (s[SW-1]) begin
         r = {1'b1, {(AW-1){1'b0}}};
      end else begin
         r = {1'b0, {(AW-1){1'b1}}};
      end
      return r;
   endfunction

   // latched indices
   logic [ADDR_W-1:0] vi_ff, ca_ff, cb_ff, cc_ff;
   // memories and read registers
   logic [3*CW-1:0] pos_mem [MAX_VERTICES];
   logic [3*AW-1:0] acc_mem [MAX_VERTICES];
   logic [3*CW-1:0] pos_rd_ff;
   logic [3*AW-1:0] acc_rd_ff;
   logic [ADDR_W-1:0] corner_addr, pos_addr, acc_addr;
   logic [3*AW-1:0] acc_wr_data;
   // triangle datapath
   logic [3*CW-1:0] pa_ff, pb_ff, pc_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [DW-1:0] n_ff [3];
   // query datapath
   logic [AW-1:0] mag_ff [3];
   logic          neg_ff [3];
   logic [AW-1:0] m_ff;
   logic [AW-1:0] mx, my, mz, mmax;
   logic [63:0]   sq_ff, root_ff, bit_ff, sqrt_t;
   logic [32:0]   len;
   logic [34:0]   rem_ff, div_trial, div_dvs;
   logic [16:0]   low_ff, quo_ff;
   logic [47:0]   numer;
   logic [AW-1:0] sel_mag;
   logic          sel_neg;
   logic signed [15:0] unit_sat, unit_val;
   logic signed [15:0] unit_ff [3];

   // status
   assign status.vi_ok     = in_range(req_vertex_index);
   assign status.tri_ok    = in_range(req_corner_a) && in_range(req_corner_b) &&
                             in_range(req_corner_c);
   assign status.acc_zero  = (m_ff == '0);
   assign status.norm_done = !(|m_ff[AW-1:NORM_HI_BIT]) && m_ff[NORM_LO_BIT];

   // address selection for the single-port memories
   always_comb begin
      unique case (cmd.sel)
         SEL_A:   corner_addr = ca_ff;
         SEL_B:   corner_addr = cb_ff;
         default: corner_addr = cc_ff;
      endcase
      pos_addr = (cmd.op == OP_POS_WRITE) ? to_addr(req_vertex_index) : corner_addr;
      priority if (cmd.op == OP_POS_WRITE) begin
         acc_addr = to_addr(req_vertex_index);
      end else if (cmd.op == OP_Q_RD) begin
         acc_addr = vi_ff;
      end else begin
         acc_addr = corner_addr;
      end
      acc_wr_data = {sat_acc(acc_rd_ff[3*AW-1:2*AW], n_ff[0]),
                     sat_acc(acc_rd_ff[2*AW-1:AW], n_ff[1]),
                     sat_acc(acc_rd_ff[AW-1:0], n_ff[2])};
   end

   // position memory
   always_ff @(posedge clock) begin
      if (cmd.op == OP_POS_WRITE) begin
         pos_mem[pos_addr] <= {CW'(req_pos_x), CW'(req_pos_y), CW'(req_pos_z)};
      end
      pos_rd_ff <= pos_mem[pos_addr];
   end

   // accumulator memory
   always_ff @(posedge clock) begin
      if (cmd.op == OP_POS_WRITE) begin
         acc_mem[acc_addr] <= '0;
      end else if (cmd.op == OP_ACC_WR) begin
         acc_mem[acc_addr] <= acc_wr_data;
      end
      acc_rd_ff <= acc_mem[acc_addr];
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == OP_CROSS) begin
         unique case (cmd.step)
            5'd0:    begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[2]); end
            5'd1:    begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[1]); end
            5'd2:    begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[0]); end
            5'd3:    begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[2]); end
            5'd4:    begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[1]); end
            5'd5:    begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         unique case (cmd.step)
            5'd0:    mul_a = MW'({1'b0, mag_ff[0][NORM_HI_BIT-1:0]});
            5'd1:    mul_a = MW'({1'b0, mag_ff[1][NORM_HI_BIT-1:0]});
            default: mul_a = MW'({1'b0, mag_ff[2][NORM_HI_BIT-1:0]});
         endcase
         mul_b = mul_a;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // query arithmetic helpers
   always_comb begin
      mx   = mag_of(acc_rd_ff[3*AW-1:2*AW]);
      my   = mag_of(acc_rd_ff[2*AW-1:AW]);
      mz   = mag_of(acc_rd_ff[AW-1:0]);
      mmax = mx;
      if (my > mmax) mmax = my;
      if (mz > mmax) mmax = mz;
      sqrt_t = root_ff + bit_ff;
      len    = root_ff[32:0];
      unique case (cmd.sel)
         SEL_A:   begin sel_mag = mag_ff[0]; sel_neg = neg_ff[0]; end
         SEL_B:   begin sel_mag = mag_ff[1]; sel_neg = neg_ff[1]; end
         default: begin sel_mag = mag_ff[2]; sel_neg = neg_ff[2]; end
      endcase
      numer     = 48'({sel_mag[NORM_HI_BIT-1:0], 16'b0}) + 48'(len);
      div_trial = {rem_ff[33:0], low_ff[16]};
      div_dvs   = {1'b0, len, 1'b0};
      unit_sat  = (quo_ff > 17'(UNIT_MAX)) ? UNIT_MAX : $signed(quo_ff[15:0]);
      unit_val  = sel_neg ? -unit_sat : unit_sat;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH: begin
            vi_ff <= to_addr(req_vertex_index);
            ca_ff <= to_addr(req_corner_a);
            cb_ff <= to_addr(req_corner_b);
            cc_ff <= to_addr(req_corner_c);
         end
         OP_RD_B:  pa_ff <= pos_rd_ff;
         OP_RD_C:  pb_ff <= pos_rd_ff;
         OP_CAP_C: pc_ff <= pos_rd_ff;
         OP_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e1_ff[k] <= EW'(coord(pb_ff, 2'(k))) - EW'(coord(pa_ff, 2'(k)));
               e2_ff[k] <= EW'(coord(pc_ff, 2'(k))) - EW'(coord(pa_ff, 2'(k)));
            end
         end
         OP_CROSS: begin
            unique case (cmd.step)
               5'd1:    n_ff[0] <= DW'(prod_ff);
               5'd2:    n_ff[0] <= n_ff[0] - DW'(prod_ff);
               5'd3:    n_ff[1] <= DW'(prod_ff);
               5'd4:    n_ff[1] <= n_ff[1] - DW'(prod_ff);
               5'd5:    n_ff[2] <= DW'(prod_ff);
               5'd6:    n_ff[2] <= n_ff[2] - DW'(prod_ff);
               default: ;
            endcase
         end
         OP_MAG: begin
            mag_ff[0] <= mx;
            mag_ff[1] <= my;
            mag_ff[2] <= mz;
            neg_ff[0] <= acc_rd_ff[3*AW-1];
            neg_ff[1] <= acc_rd_ff[2*AW-1];
            neg_ff[2] <= acc_rd_ff[AW-1];
            m_ff      <= mmax;
         end
         OP_NORM: begin
            // one bit of shift a cycle until the largest magnitude is in range
            priority if (|m_ff[AW-1:NORM_HI_BIT]) begin
               m_ff <= m_ff >> 1;
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
            end else if (!(|m_ff[AW-1:NORM_LO_BIT])) begin
               m_ff <= m_ff << 1;
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] << 1;
            end else begin
               m_ff <= m_ff;
            end
         end
         OP_SQUARE: begin
            unique case (cmd.step)
               5'd1:    sq_ff <= prod_ff[63:0];
               5'd2:    sq_ff <= sq_ff + prod_ff[63:0];
               5'd3: begin
                  sq_ff   <= sq_ff + prod_ff[63:0];
                  root_ff <= '0;
                  bit_ff  <= SQRT_BIT_INIT;
               end
               default: ;
            endcase
         end
         OP_SQRT: begin
            // one result bit per cycle
            if (sq_ff >= sqrt_t) begin
               sq_ff   <= sq_ff - sqrt_t;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_DIV_INIT: begin
            rem_ff <= 35'(numer[47:17]);
            low_ff <= numer[16:0];
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            // restoring division, one quotient bit per cycle
            if (div_trial >= div_dvs) begin
               rem_ff <= div_trial - div_dvs;
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= div_trial;
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
            low_ff <= low_ff << 1;
         end
         OP_DIV_STORE: begin
            unique case (cmd.sel)
               SEL_A:   unit_ff[0] <= unit_val;
               SEL_B:   unit_ff[1] <= unit_val;
               default: unit_ff[2] <= unit_val;
            endcase
         end
         OP_OUT_LOAD: begin
            rsp_normal_x   <= unit_ff[0];
            rsp_normal_y   <= unit_ff[1];
            rsp_normal_z   <= unit_ff[2];
            rsp_degenerate <= 1'b0;
         end
         OP_OUT_DEGEN: begin
            rsp_normal_x   <= '0;
            rsp_normal_y   <= '0;
            rsp_normal_z   <= '0;
            rsp_degenerate <= 1'b1;
         end
         default: ;
      endcase
   end

endmodule

### rtl/vng_ctrl.sv
`timescale 1ns / 1ps
module vng_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_kind,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  vng_pkg::status_type status,
   output vng_pkg::cmd_type    cmd
);
   import vng_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       load;
   logic       out_free;

   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= SEL_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sel_in    = sel_ff;
      req_stall = 1'b1;
      load      = 1'b0;
      cmd.op    = OP_NONE;
      cmd.step  = cnt_ff;
      cmd.sel   = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = OP_LATCH;
               unique case (req_kind)
                  KIND_POSITION: if (status.vi_ok) cmd.op = OP_POS_WRITE;
                  KIND_TRIANGLE: begin
                     if (status.tri_ok) begin
                        state_in = S_T_RA;
                        sel_in   = SEL_A;
                     end
                  end
                  KIND_QUERY: state_in = status.vi_ok ? S_Q_RD : S_Q_DEGEN;
                  default: ;
               endcase
            end
         end
         S_T_RA: begin
            cmd.op   = OP_RD_A;
            sel_in   = SEL_B;
            state_in = S_T_RB;
         end
         S_T_RB: begin
            cmd.op   = OP_RD_B;
            sel_in   = SEL_C;
            state_in = S_T_RC;
         end
         S_T_RC: begin
            cmd.op   = OP_RD_C;
            state_in = S_T_CAPC;
         end
         S_T_CAPC: begin
            cmd.op   = OP_CAP_C;
            state_in = S_T_EDGE;
         end
         S_T_EDGE: begin
            cmd.op   = OP_EDGE;
            cnt_in   = '0;
            state_in = S_T_CROSS;
         end
         S_T_CROSS: begin
            cmd.op = OP_CROSS;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CROSS_LAST) begin
               cnt_in   = '0;
               sel_in   = SEL_A;
               state_in = S_T_ACC_RD;
            end
         end
         S_T_ACC_RD: begin
            cmd.op   = OP_ACC_RD;
            state_in = S_T_ACC_WR;
         end
         S_T_ACC_WR: begin
            cmd.op = OP_ACC_WR;
            if (sel_ff == SEL_C) begin
               state_in = S_IDLE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_T_ACC_RD;
            end
         end
         S_Q_RD: begin
            cmd.op   = OP_Q_RD;
            state_in = S_Q_MAG;
         end
         S_Q_MAG: begin
            cmd.op   = OP_MAG;
            state_in = S_Q_NORM;
         end
         S_Q_NORM: begin
            cmd.op = OP_NORM;
            priority if (status.acc_zero) begin
               state_in = S_Q_DEGEN;
            end else if (status.norm_done) begin
               cnt_in   = '0;
               state_in = S_Q_SQ;
            end else begin
               state_in = S_Q_NORM;
            end
         end
         S_Q_SQ: begin
            cmd.op = OP_SQUARE;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = S_Q_SQRT;
            end
         end
         S_Q_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               sel_in   = SEL_A;
               state_in = S_Q_DIV_INIT;
            end
         end
         S_Q_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_Q_DIV;
         end
         S_Q_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_Q_DIV_STORE;
            end
         end
         S_Q_DIV_STORE: begin
            cmd.op = OP_DIV_STORE;
            if (sel_ff == SEL_C) begin
               state_in = S_Q_OUT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_Q_DIV_INIT;
            end
         end
         S_Q_OUT: begin
            if (out_free) begin
               cmd.op   = OP_OUT_LOAD;
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_Q_DEGEN: begin
            if (out_free) begin
               cmd.op   = OP_OUT_DEGEN;
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

### rtl/vertex_normal_generator.sv
`timescale 1ns / 1ps
// Area-weighted vertex normal generator. Items are taken one at a time. A
// position item is written in the cycle it is accepted. A triangle item makes
// three reads of the single-port position memory, six products through one
// shared multiplier, then a read and a write of the single-port accumulator
// memory per corner. A query makes k one-bit normalizing shifts (up to
// ACCUM_WIDTH - 31 right or 30 left), a bit-serial square root and three
// 17-step restoring divisions. An out-of-range query or a zero accumulator
// answers with the degenerate flag. A result waits in the output register
// while the next item is accepted.
module vertex_normal_generator #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_WIDTH  = 24,
   parameter int ACCUM_WIDTH  = 56
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [9:0]         req_vertex_index,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic [9:0]         req_corner_a,
   input  logic [9:0]         req_corner_b,
   input  logic [9:0]         req_corner_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_degenerate
);
   import vng_pkg::*;

   cmd_type    cmd;
   status_type status;

   vng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vng_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH),
      .ACCUM_WIDTH  (ACCUM_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .cmd              (cmd),
      .status           (status),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_degenerate   (rsp_degenerate)
   );

`ifndef NO_ASSERTIONS
   // an accepted query keeps the block busy in the cycle after it is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_QUERY) |=> req_stall)
      else $error("query item did not occupy the block");

   // position items complete in the accept cycle
   a_pos_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_POSITION) |=> !req_stall)
      else $error("position item stalled the input");

   // the unused kind is dropped without work
   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_UNUSED) |=> !req_stall)
      else $error("unused kind stalled the input");

   // a degenerate result carries a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         (rsp_normal_x == 16'sd0) && (rsp_normal_y == 16'sd0) && (rsp_normal_z == 16'sd0))
      else $error("degenerate result with nonzero normal");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import vng_pkg::*;

   localparam int           VERTEX_COUNT = 1024;
   localparam longint       ACC_MAX      = 64'sh007F_FFFF_FFFF_FFFF;
   localparam longint       ACC_MIN      = -ACC_MAX - 1;
   localparam int           STALL_PCT    = 9;
   localparam int           SETTLE_CYCLES = 200;
   localparam int           IDLE_LIMIT   = 5000;

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degen;
   } normal_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_POSITION;
   logic [9:0]         req_vertex_index = '0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic signed [23:0] req_pos_z = '0;
   logic [9:0]         req_corner_a = '0;
   logic [9:0]         req_corner_b = '0;
   logic [9:0]         req_corner_c = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_degenerate;

   // predictor state: positions, accumulators, and which vertices are defined
   longint  pos_x_mem [VERTEX_COUNT];
   longint  pos_y_mem [VERTEX_COUNT];
   longint  pos_z_mem [VERTEX_COUNT];
   longint  acc_x_mem [VERTEX_COUNT];
   longint  acc_y_mem [VERTEX_COUNT];
   longint  acc_z_mem [VERTEX_COUNT];
   bit      vertex_written [VERTEX_COUNT];
   int      written_list[$];
   normal_type expected_normals[$];

   int fail_count = 0;
   bit idle_enable = 1'b1;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   vertex_normal_generator i_dut (.*);

   always #5 clock = ~clock;

   // saturating add at the accumulator width
   function automatic longint acc_add(longint a, longint d);
      longint s;
      s = a + d;
      if (s > ACC_MAX) s = ACC_MAX;
      if (s < ACC_MIN) s = ACC_MIN;
      return s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // rounded |c| * 2^15 / len, saturated, sign restored
   function automatic logic signed [15:0] unit_component(longint unsigned m, bit neg,
                                                         longint unsigned len);
      longint unsigned q;
      q = (2 * m * 32768 + len) / (2 * len);
      if (q > 32767) q = 32767;
      return neg ? -$signed(q[15:0]) : $signed(q[15:0]);
   endfunction

   function automatic normal_type vertex_normal(int vi);
      normal_type n;
      longint unsigned mx, my, mz, m, len;
      n = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
      mx = acc_x_mem[vi] < 0 ? -acc_x_mem[vi] : acc_x_mem[vi];
      my = acc_y_mem[vi] < 0 ? -acc_y_mem[vi] : acc_y_mem[vi];
      mz = acc_z_mem[vi] < 0 ? -acc_z_mem[vi] : acc_z_mem[vi];
      m = mx;
      if (my > m) m = my;
      if (mz > m) m = mz;
      if (m == 0) return n;
      while (m >= 64'd1 << 31) begin
         m = m >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
      end
      while (m < 64'd1 << 30) begin
         m = m << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
      end
      len = int_sqrt(mx * mx + my * my + mz * mz);
      n.nx = unit_component(mx, acc_x_mem[vi] < 0, len);
      n.ny = unit_component(my, acc_y_mem[vi] < 0, len);
      n.nz = unit_component(mz, acc_z_mem[vi] < 0, len);
      n.degen = 1'b0;
      return n;
   endfunction

   // update the mesh model with one accepted item
   task automatic mesh_update(logic [1:0] kind, int vi, logic signed [23:0] px,
                              logic signed [23:0] py, logic signed [23:0] pz,
                              int a, int b, int c);
      longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
      int corners[3];
      case (kind)
         KIND_POSITION: begin
            pos_x_mem[vi] = px; pos_y_mem[vi] = py; pos_z_mem[vi] = pz;
            acc_x_mem[vi] = 0; acc_y_mem[vi] = 0; acc_z_mem[vi] = 0;
            if (!vertex_written[vi]) written_list = {written_list, vi};
            vertex_written[vi] = 1'b1;
         end
         KIND_TRIANGLE: begin
            e1x = pos_x_mem[b] - pos_x_mem[a];
            e1y = pos_y_mem[b] - pos_y_mem[a];
            e1z = pos_z_mem[b] - pos_z_mem[a];
            e2x = pos_x_mem[c] - pos_x_mem[a];
            e2y = pos_y_mem[c] - pos_y_mem[a];
            e2z = pos_z_mem[c] - pos_z_mem[a];
            nx = e1y * e2z - e1z * e2y;
            ny = e1z * e2x - e1x * e2z;
            nz = e1x * e2y - e1y * e2x;
            corners = '{a, b, c};
            foreach (corners[k]) begin
               acc_x_mem[corners[k]] = acc_add(acc_x_mem[corners[k]], nx);
               acc_y_mem[corners[k]] = acc_add(acc_y_mem[corners[k]], ny);
               acc_z_mem[corners[k]] = acc_add(acc_z_mem[corners[k]], nz);
            end
         end
         KIND_QUERY: expected_normals = {expected_normals, vertex_normal(vi)};
         default: ;
      endcase
   endtask

   // offer one item, hold it until accepted, then record it
   task automatic send_item(logic [1:0] kind, int vi, logic signed [23:0] px,
                            logic signed [23:0] py, logic signed [23:0] pz,
                            int a, int b, int c);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_vertex_index <= 10'(vi);
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_corner_a <= 10'(a);
      req_corner_b <= 10'(b);
      req_corner_c <= 10'(c);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mesh_update(kind, vi, px, py, pz, a, b, c);
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(8192)) - 4096);
         2: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
         default: return 24'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   task automatic send_position(int vi, logic signed [23:0] x, logic signed [23:0] y,
                                logic signed [23:0] z);
      send_item(KIND_POSITION, vi, x, y, z, $urandom, $urandom, $urandom);
   endtask

   task automatic send_triangle(int a, int b, int c);
      send_item(KIND_TRIANGLE, $urandom, 24'($urandom), 24'($urandom), 24'($urandom),
                a, b, c);
   endtask

   task automatic send_query(int vi);
      send_item(KIND_QUERY, vi, 24'($urandom), 24'($urandom), 24'($urandom), $urandom,
                $urandom, $urandom);
   endtask

   function automatic int pick_written();
      return written_list[$urandom_range(written_list.size() - 1)];
   endfunction

   // extremes, every kind, zero and repeated corners
   task automatic test_directed();
      send_position(0, -24'sh800000, -24'sh800000, -24'sh800000);
      send_position(1023, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
      send_position(512, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
      send_query(0);
      send_triangle(0, 1023, 512);
      send_query(0);
      send_query(1023);
      send_query(512);
      send_triangle(0, 0, 1023);
      send_triangle(512, 512, 512);
      send_query(512);
      send_item(KIND_UNUSED, 1023, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1023, 1023, 1023);
      send_position(1, 0, 0, 0);
      send_position(2, 1, 0, 0);
      send_position(3, 0, 1, 0);
      send_triangle(1, 2, 3);
      send_query(1);
      send_triangle(1, 3, 2);
      send_query(2);
      send_position(0, 5, -7, 3);
      send_query(0);
   endtask

   // drive accumulators into both saturation limits (x and z up, y down)
   task automatic test_saturation();
      send_position(10, -24'sh800000, -24'sh800000, 0);
      send_position(11, 24'sh7FFFFF, 0, -24'sh800000);
      send_position(12, 0, 24'sh7FFFFF, 24'sh7FFFFF);
      repeat (180) send_triangle(10, 11, 12);
      send_query(10);
      send_query(11);
      repeat (20) send_triangle(10, 12, 11);
      send_query(12);
      send_query(10);
   endtask

   // receiver holds off while queries keep coming
   task automatic test_backpressure();
      hold_cycles = 400;
      repeat (12) send_query(pick_written());
   endtask

   task automatic test_random(int count);
      int a, b;
      for (int n = 0; n < count; n++) begin
         idle_enable = !(n >= count / 3 && n < count / 3 + 60);
         case ($urandom_range(19))
            0, 1, 2, 3, 4:
               send_position($urandom_range(1) ? $urandom_range(VERTEX_COUNT - 1)
                             : $urandom_range(31), rand_coord(), rand_coord(), rand_coord());
            5, 6, 7, 8, 9, 10, 11, 12: begin
               a = pick_written();
               b = pick_written();
               send_triangle(a, b, $urandom_range(3) == 0 ? a : pick_written());
            end
            13: send_item(KIND_UNUSED, $urandom, 24'($urandom), 24'($urandom),
                          24'($urandom), $urandom, $urandom, $urandom);
            default: send_query(pick_written());
         endcase
      end
      idle_enable = 1'b1;
   endtask

   // result side stall: random, or a long hold when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= idle_enable && $urandom_range(99) < STALL_PCT;
      end
   end

   // compare each result with the oldest expected normal
   always @(posedge clock) begin
      normal_type n;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            $error("unexpected result: nx %0d ny %0d nz %0d degenerate %0b",
                   rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
            fail_count++;
         end else begin
            n = expected_normals.pop_front();
            if (rsp_normal_x !== n.nx) begin
               $error("normal_x: expected %0d, got %0d", n.nx, rsp_normal_x);
               fail_count++;
            end
            if (rsp_normal_y !== n.ny) begin
               $error("normal_y: expected %0d, got %0d", n.ny, rsp_normal_y);
               fail_count++;
            end
            if (rsp_normal_z !== n.nz) begin
               $error("normal_z: expected %0d, got %0d", n.nz, rsp_normal_z);
               fail_count++;
            end
            if (rsp_degenerate !== n.degen) begin
               $error("degenerate: expected %0b, got %0b", n.degen, rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("vertex_normal_generator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_saturation();
      test_backpressure();
      test_random(210);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("vertex_normal_generator regression: pass");
      end else begin
         $display("vertex_normal_generator regression: fail");
      end
      $finish;
   end

endmodule

### files.f
rtl/vng_pkg.sv
rtl/vng_dpath.sv
rtl/vng_ctrl.sv
rtl/vertex_normal_generator.sv
tb/sv/testbench.sv
